[design/slt_pkg.sv]
`timescale 1ns / 1ps

package slt_pkg;

  localparam int CAPACITY = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic [1:0]              op;
    logic signed [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic       found;
    logic [5:0] position;
    logic [5:0] count;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic take_left;
    logic take_right;
  } cell_ctl_t;

  typedef struct packed {
    logic lt;
    logic eq;
  } cell_flags_t;

endpackage

[design/slt_cell.sv]
`timescale 1ns / 1ps

module slt_cell (
  input  logic                             clk,
  input  slt_pkg::cell_ctl_t               ctl,
  input  logic signed [slt_pkg::VAL_W-1:0] left,
  input  logic signed [slt_pkg::VAL_W-1:0] right,
  input  logic signed [slt_pkg::VAL_W-1:0] key,
  output logic signed [slt_pkg::VAL_W-1:0] value,
  output slt_pkg::cell_flags_t             flags
);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      value <= key;
    end else if (ctl.take_left) begin
      value <= left;
    end else if (ctl.take_right) begin
      value <= right;
    end
  end

  always_comb begin
    flags.lt = value < key;
    flags.eq = value == key;
  end

endmodule

[design/sorted_list_table_core.sv]
`timescale 1ns / 1ps

// Sorted table of signed 32-bit values held in ascending order in a row of cells.
// A request word on req (req_valid/req_ready) carries an operation and a value:
// insert, delete the first match, search, or clear. Each request gives exactly one
// response word on rsp (rsp_valid/rsp_ready) with status, found flag, rank and count.
// A request is taken only while the core is idle. In the compare step every cell
// compares its entry with the value and the flags are registered; in the apply step
// the rank is encoded from the flags, the cells shift or load, and the response word
// is registered. The core takes no new request until the apply step of the last one
// is done, so requests are handled one at a time.
// If the receiver stalls, a finished response waits in the output register; the core
// can take and compare one more request meanwhile, but holds it before changing the
// table until the output register is free.
// Reset empties the table and drops any response in flight; cell contents are not
// cleared, since entries beyond the count are never read.

module sorted_list_table_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  slt_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output slt_pkg::rsp_t rsp
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CMP   = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;

  localparam int N = slt_pkg::CAPACITY;
  localparam int W = slt_pkg::CNT_W;

  logic [1:0]                       state;
  logic [1:0]                       op;
  logic signed [slt_pkg::VAL_W-1:0] key;
  logic [W-1:0]                     count;
  logic [W-1:0]                     count_next;
  logic [N-1:0]                     lt_vec;
  logic [N-1:0]                     eq_vec;
  logic [N-1:0]                     lt_raw;
  logic [N-1:0]                     eq_raw;
  logic [N-1:0]                     valid_vec;
  logic [N-1:0]                     sel;
  logic [W-1:0]                     pos_enc;
  logic [W-1:0]                     pos;
  logic                             hit;
  logic                             fire;
  slt_pkg::rsp_t                    rsp_next;
  slt_pkg::cell_ctl_t               ctl [N];
  slt_pkg::cell_ctl_t               ctl_next [N];
  logic signed [slt_pkg::VAL_W-1:0] cell_val [N];
  slt_pkg::cell_flags_t             cell_flags [N];

  assign req_ready = (state == S_IDLE);
  assign fire      = (state == S_APPLY) && (!rsp_valid || rsp_ready);

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic signed [slt_pkg::VAL_W-1:0] left_val;
    logic signed [slt_pkg::VAL_W-1:0] right_val;

    if (i == 0) begin : g_first
      assign left_val = cell_val[i];
    end else begin : g_mid_l
      assign left_val = cell_val[i-1];
    end
    if (i == N - 1) begin : g_last
      assign right_val = cell_val[i];
    end else begin : g_mid_r
      assign right_val = cell_val[i+1];
    end

    assign ctl[i]       = fire ? ctl_next[i] : '0;
    assign lt_raw[i]    = cell_flags[i].lt;
    assign eq_raw[i]    = cell_flags[i].eq;
    assign valid_vec[i] = W'(i) < count;

    slt_cell u_cell (
      .clk   (clk),
      .ctl   (ctl[i]),
      .left  (left_val),
      .right (right_val),
      .key   (key),
      .value (cell_val[i]),
      .flags (cell_flags[i])
    );
  end

  always_comb begin
    pos_enc = '0;
    sel[0]  = ~lt_vec[0];
    for (int i = 1; i < N; i++) begin
      sel[i] = ~lt_vec[i] & lt_vec[i-1];
      if (sel[i]) begin
        pos_enc = pos_enc | W'(i);
      end
    end
    pos = (|sel) ? pos_enc : W'(N);
    hit = |(sel & eq_vec);
  end

  always_comb begin
    rsp_next   = '0;
    count_next = count;
    for (int i = 0; i < N; i++) begin
      ctl_next[i] = '0;
    end
    unique case (op)
      slt_pkg::OP_INSERT: begin
        if (count == W'(N)) begin
          rsp_next.status = slt_pkg::ST_FULL;
        end else begin
          rsp_next.position = 6'(pos);
          count_next        = count + W'(1);
          for (int i = 0; i < N; i++) begin
            ctl_next[i].load      = sel[i];
            ctl_next[i].take_left = ~lt_vec[i] & ~sel[i];
          end
        end
      end
      slt_pkg::OP_CLEAR: begin
        if (count == '0) begin
          rsp_next.status = slt_pkg::ST_EMPTY;
        end else begin
          count_next = '0;
        end
      end
      default: begin
        if (count == '0) begin
          rsp_next.status = slt_pkg::ST_EMPTY;
        end else if (!hit) begin
          rsp_next.status = slt_pkg::ST_NOTFOUND;
        end else begin
          rsp_next.found    = 1'b1;
          rsp_next.position = 6'(pos);
          if (op == slt_pkg::OP_DELETE) begin
            count_next = count - W'(1);
            for (int i = 0; i < N; i++) begin
              ctl_next[i].take_right = ~lt_vec[i];
            end
          end
        end
      end
    endcase
    rsp_next.count = 6'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          state <= S_APPLY;
        end
        S_APPLY: begin
          if (fire) begin
            state     <= S_IDLE;
            count     <= count_next;
            rsp_valid <= 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid) begin
      op  <= req.op;
      key <= req.value;
    end
    if (state == S_CMP) begin
      lt_vec <= lt_raw & valid_vec;
      eq_vec <= eq_raw & valid_vec;
    end
    if (fire) begin
      rsp <= rsp_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= W'(N))
    else $error("entry count exceeds capacity");

  a_lt_prefix: assert property (@(posedge clk) disable iff (rst)
    state == S_APPLY |-> (lt_vec & (lt_vec + N'(1))) == '0)
    else $error("less-than flags do not form a prefix");

  a_rsp_from_apply: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == S_APPLY)
    else $error("response raised outside the apply step");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == slt_pkg::ST_FULL |-> count == W'(N))
    else $error("full status with free entries");

endmodule

[verif/sorted_list_table_core_tb.sv]
`timescale 1ns / 1ps

module sorted_list_table_core_tb;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  slt_pkg::req_t req;
  logic rsp_valid;
  logic rsp_ready;
  slt_pkg::rsp_t rsp;

  slt_pkg::req_t pending_words[$];
  slt_pkg::rsp_t due_rsps[$];

  logic signed [slt_pkg::VAL_W-1:0] shadow_vals [slt_pkg::CAPACITY];
  int shadow_count;

  int send_idle_pct;
  int rsp_stall_pct;
  int mismatches;

  sorted_list_table_core u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Applies one request word to the shadow table and queues the response it must give.
  task automatic apply_table_op(input slt_pkg::req_t w);
    slt_pkg::rsp_t r;
    int i;
    int k;
    r = '0;
    r.status = slt_pkg::ST_OK;
    if (w.op == slt_pkg::OP_INSERT) begin
      if (shadow_count >= slt_pkg::CAPACITY) begin
        r.status = slt_pkg::ST_FULL;
      end else begin
        i = 0;
        while (i < shadow_count && $signed(shadow_vals[i]) < $signed(w.value)) i++;
        for (k = shadow_count; k > i; k--) shadow_vals[k] = shadow_vals[k-1];
        shadow_vals[i] = w.value;
        shadow_count++;
        r.position = 6'(i);
      end
    end else if (shadow_count == 0) begin
      r.status = slt_pkg::ST_EMPTY;
    end else if (w.op == slt_pkg::OP_CLEAR) begin
      shadow_count = 0;
    end else begin
      i = 0;
      while (i < shadow_count && shadow_vals[i] != w.value) i++;
      if (i >= shadow_count) begin
        r.status = slt_pkg::ST_NOTFOUND;
      end else begin
        r.found = 1'b1;
        r.position = 6'(i);
        if (w.op == slt_pkg::OP_DELETE) begin
          for (k = i; k < shadow_count - 1; k++) shadow_vals[k] = shadow_vals[k+1];
          shadow_count--;
        end
      end
    end
    r.count = 6'(shadow_count);
    due_rsps.push_back(r);
  endtask

  function automatic void check_field(input string name, input int want, input logic [5:0] got);
    if (got !== 6'(want)) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : req_drive
    logic take;
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) apply_table_op(req);
      if (!req_valid || req_ready) begin
        take = (pending_words.size() > 0) && ($urandom_range(0, 99) >= send_idle_pct);
        if (take) begin
          req <= pending_words.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : rsp_check
    slt_pkg::rsp_t want;
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (due_rsps.size() == 0) begin
          $error("unexpected response word: status %0d found %0d position %0d count %0d",
                 rsp.status, rsp.found, rsp.position, rsp.count);
          mismatches++;
        end else begin
          want = due_rsps.pop_front();
          check_field("status", want.status, 6'(rsp.status));
          check_field("found", want.found, 6'(rsp.found));
          check_field("position", want.position, rsp.position);
          check_field("count", want.count, rsp.count);
        end
      end
      rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
    end
  end

  function automatic void push_word(input logic [1:0] op, input logic [31:0] value);
    slt_pkg::req_t w;
    w.op = op;
    w.value = value;
    pending_words.push_back(w);
  endfunction

  function automatic logic [31:0] pick_value(input logic [31:0] pool [8]);
    if ($urandom_range(0, 99) < 85) return pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  // Fills the request queue with episodes that share a small value pool, so that
  // duplicates, hits and a full table are common; misses come from fresh random values.
  task automatic queue_random_words(input int n);
    logic [31:0] pool [8];
    logic [31:0] extremes [4];
    logic [1:0] op;
    int len;
    int ins_pct;
    int roll;
    int p;
    bit first;
    extremes[0] = 32'h8000_0000;
    extremes[1] = 32'h7FFF_FFFF;
    extremes[2] = 32'h0000_0000;
    extremes[3] = 32'hFFFF_FFFF;
    first = 1'b1;
    while (pending_words.size() < n) begin
      for (p = 0; p < 8; p++) begin
        case ($urandom_range(0, 3))
          0: pool[p] = 32'($urandom_range(0, 15)) - 32'd8;
          1: pool[p] = extremes[$urandom_range(0, 3)];
          default: pool[p] = $urandom;
        endcase
      end
      if (first || $urandom_range(0, 9) == 0) begin
        push_word(slt_pkg::OP_CLEAR, $urandom);
        for (p = 0; p < slt_pkg::CAPACITY + 3; p++) begin
          push_word(slt_pkg::OP_INSERT, pick_value(pool));
        end
        for (p = 0; p < 20; p++) begin
          op = $urandom_range(0, 1) ? slt_pkg::OP_DELETE : slt_pkg::OP_SEARCH;
          push_word(op, pick_value(pool));
        end
        first = 1'b0;
      end else begin
        len = $urandom_range(20, 80);
        ins_pct = $urandom_range(30, 80);
        for (p = 0; p < len; p++) begin
          roll = $urandom_range(0, 99);
          if (roll < ins_pct) op = slt_pkg::OP_INSERT;
          else if (roll >= 98) op = slt_pkg::OP_CLEAR;
          else op = $urandom_range(0, 1) ? slt_pkg::OP_DELETE : slt_pkg::OP_SEARCH;
          push_word(op, pick_value(pool));
        end
      end
    end
  endtask

  task automatic drain;
    while (pending_words.size() != 0 || req_valid || due_rsps.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int n);
    send_idle_pct <= idle_pct;
    rsp_stall_pct <= stall_pct;
    queue_random_words(n);
    drain();
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    rsp_ready = 1'b0;
    send_idle_pct = 0;
    rsp_stall_pct = 0;
    mismatches = 0;
    shadow_count = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    push_word(slt_pkg::OP_SEARCH, 32'd5);
    push_word(slt_pkg::OP_DELETE, 32'd5);
    push_word(slt_pkg::OP_CLEAR, 32'd0);
    push_word(slt_pkg::OP_INSERT, 32'd0);
    push_word(slt_pkg::OP_INSERT, 32'h7FFF_FFFF);
    push_word(slt_pkg::OP_INSERT, 32'h8000_0000);
    push_word(slt_pkg::OP_INSERT, 32'hFFFF_FFFF);
    push_word(slt_pkg::OP_INSERT, 32'd0);
    push_word(slt_pkg::OP_INSERT, 32'd1);
    push_word(slt_pkg::OP_SEARCH, 32'd0);
    push_word(slt_pkg::OP_SEARCH, 32'h7FFF_FFFF);
    push_word(slt_pkg::OP_SEARCH, 32'h8000_0000);
    push_word(slt_pkg::OP_SEARCH, 32'd12345);
    push_word(slt_pkg::OP_DELETE, 32'd0);
    push_word(slt_pkg::OP_SEARCH, 32'd0);
    push_word(slt_pkg::OP_DELETE, 32'd42);
    push_word(slt_pkg::OP_DELETE, 32'h8000_0000);
    push_word(slt_pkg::OP_DELETE, 32'h7FFF_FFFF);
    push_word(slt_pkg::OP_CLEAR, 32'hFFFF_FFFF);
    push_word(slt_pkg::OP_SEARCH, 32'hFFFF_FFFF);
    push_word(slt_pkg::OP_INSERT, 32'h5555_5555);
    push_word(slt_pkg::OP_INSERT, 32'hAAAA_AAAA);

    run_phase(0, 0, 280);
    run_phase(77, 0, 260);
    run_phase(0, 77, 260);
    run_phase(7, 7, 260);

    repeat (20) @(posedge clk);
    if (due_rsps.size() != 0) begin
      $error("responses: expected %0d more, got 0", due_rsps.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
